// File: rtl/core/windowed_interval_quantizer_core_defines.svh
// Assertion macros shared by the interval quantizer RTL.
// No dependencies; taken in by the files that carry checks.
`ifndef WINDOWED_INTERVAL_QUANTIZER_CORE_DEFINES_SVH
`define WINDOWED_INTERVAL_QUANTIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WIQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("interval quantizer check failed");

// Next-cycle implication, disabled while in reset.
`define WIQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("interval quantizer check failed");

`endif

// File: rtl/core/wiq_pkg.sv
// Shared types, codes and widths for the interval quantizer core.
// No dependencies; used by every module of the block.
package wiq_pkg;

  localparam int REGION_SLOTS_DEF = 128;
  localparam int DIM_BITS_DEF     = 12;

  localparam int CMD_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int SLOT_W     = 7;
  localparam int GRAY_W     = 8;
  localparam int REGION_W   = 7;
  localparam int COUNT_W    = 25;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int WIN_W      = 13;
  localparam int NTHR_W     = 6;
  localparam int ROW_W      = 13;
  localparam int THR_DEPTH  = 64;
  localparam int THR_AW     = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ROW_W-1:0]   ROW_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ELEM  = 3'd0,
    CMD_THR   = 3'd1,
    CMD_COLOR = 3'd2,
    CMD_READ  = 3'd3,
    CMD_START = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS     = 3'd0,
    CFG_ROWS     = 3'd1,
    CFG_COL_LOW  = 3'd2,
    CFG_ROW_LOW  = 3'd3,
    CFG_COL_HIGH = 3'd4,
    CFG_ROW_HIGH = 3'd5,
    CFG_NTHR     = 3'd6,
    CFG_STATS    = 3'd7
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  typedef struct packed {
    logic start;
    logic thr_we;
  } cls_ctl_t;

  typedef struct packed {
    logic                done;
    logic [REGION_W-1:0] region;
  } cls_sts_t;

  typedef struct packed {
    logic gray_we;
    logic cnt_we;
    logic clear;
  } stats_ctl_t;

endpackage

// File: rtl/core/windowed_interval_quantizer_core.sv
// An element passes through DECODE, CHECK, SCAN and READ before the next accept; the scan
// compares m thresholds, 1 up to num_thresholds (at most 63), or none with no thresholds
// in use. An element past the matrix end goes from CHECK back to idle. The single signed
// comparator walks the threshold table one entry a cycle. Threshold, colour and start words
// go from DECODE back to idle, a count read through READ. Each result word is shown for one
// cycle with out_valid and cannot be held off; the next word may be started in that same
// cycle. Counts clear at once on reset and start, with no clearing pass. The user must
// write configuration through cfg_* only while busy is low; the block does not enforce it.
`include "windowed_interval_quantizer_core_defines.svh"

module windowed_interval_quantizer_core #(
  parameter int REGION_SLOTS = wiq_pkg::REGION_SLOTS_DEF,
  parameter int DIM_BITS     = wiq_pkg::DIM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [wiq_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [wiq_pkg::VALUE_W-1:0] in_value,
  input  logic [wiq_pkg::SLOT_W-1:0]         in_slot,
  input  logic [wiq_pkg::GRAY_W-1:0]         in_gray,
  output logic                               out_valid,
  output logic [wiq_pkg::GRAY_W-1:0]         out_gray_out,
  output logic [wiq_pkg::REGION_W-1:0]       out_region,
  output logic                               out_in_window,
  output logic                               out_row_done,
  output logic                               out_matrix_done,
  output logic [wiq_pkg::COUNT_W-1:0]        out_region_count,
  output logic [wiq_pkg::STATUS_W-1:0]       out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wiq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wiq_pkg::*;

  localparam int AW   = $clog2(REGION_SLOTS);
  localparam int C1W  = DIM_BITS + 1;
  localparam int DW   = (DIM_BITS + 1 < 13) ? DIM_BITS + 1 : 13;
  localparam int TW   = 2 * DW;
  localparam int CMPW = (DIM_BITS + 1 > 14) ? DIM_BITS + 1 : 14;
  localparam int NLIM = (REGION_SLOTS - 1) / 2;
  localparam logic [CMPW-1:0] DIM_MAX = CMPW'(1) << DIM_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  // configuration
  logic [WIN_W-1:0]  cfg_cols_r, cfg_rows_r;
  logic [WIN_W-1:0]  cfg_cl_r, cfg_rl_r, cfg_ch_r, cfg_rh_r;
  logic [NTHR_W-1:0] cfg_nthr_r;
  logic              cfg_stats_r;

  // sequencer and latched word
  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [VALUE_W-1:0] value_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [GRAY_W-1:0]  gray_r;

  // matrix position
  logic [DIM_BITS-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0]    row_pos_r, row_pos_nxt;
  logic [TW-1:0]       elem_cnt_r, elem_cnt_nxt;

  // per-element working registers
  logic [DW-1:0]   cols_r, rows_r, cols_nxt, rows_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic            inw_r, wrap_r, last_r, inw_nxt, wrap_nxt, last_nxt;
  logic [CMPW-1:0] rl_r, rh_r, rl_nxt, rh_nxt;
  logic [C1W-1:0]  c1_r, c1_nxt;

  // result word
  logic                out_valid_r, out_valid_nxt;
  logic [GRAY_W-1:0]   res_gray_r, res_gray_nxt;
  logic [REGION_W-1:0] res_region_r, res_region_nxt;
  logic                res_inw_r, res_inw_nxt;
  logic                res_rowd_r, res_rowd_nxt;
  logic                res_mdone_r, res_mdone_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // datapath helpers
  logic [CMPW-1:0]   nc_w, nr_w, cols_c, rows_c;
  logic [C1W-1:0]    c1;
  logic [CMPW-1:0]   c1_w, r1_w, cl_e, ch_e, rl_e, rh_e;
  logic              inv;
  logic [ROW_W-1:0]  row_new;
  logic [NTHR_W-1:0] n_eff;
  logic              slot_thr_ok, slot_rs_ok;
  logic [COUNT_W-1:0] cnt_cur, gray_unused_chk;

  // submodule links
  cls_ctl_t           cls_ctl;
  cls_sts_t           cls_sts;
  stats_ctl_t         stats_ctl;
  logic [AW-1:0]      st_rd_addr, st_wr_addr;
  logic [GRAY_W-1:0]  st_gray_q;
  logic [COUNT_W-1:0] st_cnt_q;

  assign cfg_ready = 1'b1;
  assign busy      = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r  <= WIN_W'(1);
      cfg_rows_r  <= WIN_W'(1);
      cfg_cl_r    <= WIN_W'(1);
      cfg_rl_r    <= WIN_W'(1);
      cfg_ch_r    <= '0;
      cfg_rh_r    <= '0;
      cfg_nthr_r  <= NTHR_W'(1);
      cfg_stats_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLS:     cfg_cols_r  <= cfg_data;
        CFG_ROWS:     cfg_rows_r  <= cfg_data;
        CFG_COL_LOW:  cfg_cl_r    <= cfg_data;
        CFG_ROW_LOW:  cfg_rl_r    <= cfg_data;
        CFG_COL_HIGH: cfg_ch_r    <= cfg_data;
        CFG_ROW_HIGH: cfg_rh_r    <= cfg_data;
        CFG_NTHR:     cfg_nthr_r  <= cfg_data[NTHR_W-1:0];
        CFG_STATS:    cfg_stats_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // dimensions saturate to 1 .. 2^DIM_BITS
  assign nc_w   = CMPW'(cfg_cols_r);
  assign nr_w   = CMPW'(cfg_rows_r);
  assign cols_c = (nc_w == '0) ? CMPW'(1) : ((nc_w > DIM_MAX) ? DIM_MAX : nc_w);
  assign rows_c = (nr_w == '0) ? CMPW'(1) : ((nr_w > DIM_MAX) ? DIM_MAX : nr_w);

  assign n_eff = ({2'b00, cfg_nthr_r} > 8'(NLIM)) ? NTHR_W'(NLIM) : cfg_nthr_r;

  assign slot_thr_ok = slot_r < SLOT_W'(THR_DEPTH);
  assign slot_rs_ok  = int'(slot_r) < REGION_SLOTS;

  // window, taking an inverted window as the whole matrix
  assign c1   = C1W'(col_pos_r) + C1W'(1);
  assign c1_w = CMPW'(c1);
  assign r1_w = CMPW'(row_pos_r) + CMPW'(1);
  assign inv  = (cfg_cl_r > cfg_ch_r) || (cfg_rl_r > cfg_rh_r);
  assign cl_e = inv ? CMPW'(1) : CMPW'(cfg_cl_r);
  assign ch_e = inv ? CMPW'(cols_r) : CMPW'(cfg_ch_r);
  assign rl_e = inv ? CMPW'(1) : CMPW'(cfg_rl_r);
  assign rh_e = inv ? CMPW'(rows_r) : CMPW'(cfg_rh_r);

  assign row_new = (row_pos_r < ROW_MAX) ? row_pos_r + ROW_W'(1) : row_pos_r;
  assign cnt_cur = st_cnt_q;
  assign gray_unused_chk = '0;

  always_comb begin
    state_nxt    = state_r;
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    elem_cnt_nxt = elem_cnt_r;
    cols_nxt     = cols_r;
    rows_nxt     = rows_r;
    total_nxt    = total_r;
    inw_nxt      = inw_r;
    wrap_nxt     = wrap_r;
    last_nxt     = last_r;
    rl_nxt       = rl_r;
    rh_nxt       = rh_r;
    c1_nxt       = c1_r;

    out_valid_nxt  = 1'b0;
    res_gray_nxt   = '0;
    res_region_nxt = '0;
    res_inw_nxt    = 1'b0;
    res_rowd_nxt   = 1'b0;
    res_mdone_nxt  = 1'b0;
    res_count_nxt  = gray_unused_chk;
    res_status_nxt = ST_OK;

    cls_ctl   = '0;
    stats_ctl = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd_r)
          CMD_ELEM: begin
            cols_nxt  = DW'(cols_c);
            rows_nxt  = DW'(rows_c);
            total_nxt = TW'(DW'(cols_c)) * TW'(DW'(rows_c));
            state_nxt = S_CHECK;
          end
          CMD_THR: begin
            cls_ctl.thr_we = slot_thr_ok;
            res_status_nxt = slot_thr_ok ? ST_OK : ST_BAD_SLOT;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
          CMD_COLOR: begin
            stats_ctl.gray_we = slot_rs_ok;
            res_status_nxt    = slot_rs_ok ? ST_OK : ST_BAD_SLOT;
            out_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end
          CMD_READ: begin
            if (slot_rs_ok) begin
              state_nxt = S_READ;
            end else begin
              res_status_nxt = ST_BAD_SLOT;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          CMD_START: begin
            col_pos_nxt     = '0;
            row_pos_nxt     = '0;
            elem_cnt_nxt    = '0;
            stats_ctl.clear = 1'b1;
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        if (elem_cnt_r >= total_r) begin
          // drop the word, nothing moves
          res_status_nxt = ST_PAST_END;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cls_ctl.start = 1'b1;
          inw_nxt  = (c1_w >= cl_e) && (c1_w <= ch_e) && (r1_w >= rl_e) && (r1_w <= rh_e);
          wrap_nxt = c1_w >= CMPW'(cols_r);
          last_nxt = (elem_cnt_r + TW'(1)) == total_r;
          rl_nxt   = rl_e;
          rh_nxt   = rh_e;
          c1_nxt   = c1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cls_sts.done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (cmd_r == CMD_READ) begin
          res_count_nxt = cfg_stats_r ? st_cnt_q : '0;
        end else begin
          stats_ctl.cnt_we = inw_r && (cnt_cur != COUNT_MAX);
          res_gray_nxt     = st_gray_q;
          res_region_nxt   = cls_sts.region;
          res_inw_nxt      = inw_r;
          res_mdone_nxt    = last_r;
          elem_cnt_nxt     = elem_cnt_r + TW'(1);
          if (wrap_r) begin
            col_pos_nxt  = '0;
            row_pos_nxt  = row_new;
            res_rowd_nxt = (CMPW'(row_new) >= rl_r) && (CMPW'(row_new) <= rh_r);
          end else begin
            col_pos_nxt = DIM_BITS'(c1_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r   <= cmd_t'(in_cmd);
      value_r <= in_value;
      slot_r  <= in_slot;
      gray_r  <= in_gray;
    end
    cols_r       <= cols_nxt;
    rows_r       <= rows_nxt;
    total_r      <= total_nxt;
    inw_r        <= inw_nxt;
    wrap_r       <= wrap_nxt;
    last_r       <= last_nxt;
    rl_r         <= rl_nxt;
    rh_r         <= rh_nxt;
    c1_r         <= c1_nxt;
    res_gray_r   <= res_gray_nxt;
    res_region_r <= res_region_nxt;
    res_inw_r    <= res_inw_nxt;
    res_rowd_r   <= res_rowd_nxt;
    res_mdone_r  <= res_mdone_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
  end

  // read at the region as the scan finishes, otherwise at the slot
  assign st_rd_addr = (state_r == S_SCAN) ? AW'(cls_sts.region) : AW'(slot_r);
  assign st_wr_addr = (state_r == S_READ) ? AW'(cls_sts.region) : AW'(slot_r);

  wiq_classifier u_cls (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cls_ctl),
    .thr_addr  (THR_AW'(slot_r)),
    .thr_wdata (value_r),
    .elem      ($signed(value_r)),
    .n_thr     (n_eff),
    .sts       (cls_sts)
  );

  wiq_stats #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stats_ctl),
    .rd_addr    (st_rd_addr),
    .wr_addr    (st_wr_addr),
    .gray_wdata (gray_r),
    .cnt_wdata  (cnt_cur + COUNT_W'(1)),
    .gray_q     (st_gray_q),
    .cnt_q      (st_cnt_q)
  );

  assign out_valid        = out_valid_r;
  assign out_gray_out     = res_gray_r;
  assign out_region       = res_region_r;
  assign out_in_window    = res_inw_r;
  assign out_row_done     = res_rowd_r;
  assign out_matrix_done  = res_mdone_r;
  assign out_region_count = res_count_r;
  assign out_status       = res_status_r;

  `WIQ_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE)
  `WIQ_ASSERT_NXT(a_accept_decode, clk, rst_n, start && !busy, state_r == S_DECODE)
  `WIQ_ASSERT_NXT(a_scan_start, clk, rst_n, cls_ctl.start, state_r == S_SCAN)
  `WIQ_ASSERT_IMP(a_cnt_we_read, clk, rst_n, stats_ctl.cnt_we, state_r == S_READ && inw_r)
  `WIQ_ASSERT_IMP(a_past_end_quiet, clk, rst_n, out_valid_r && res_status_r == ST_PAST_END,
    res_region_r == '0 && !res_inw_r && !res_rowd_r && !res_mdone_r)

endmodule

// File: rtl/core/wiq_classifier.sv
// Threshold store and the shared signed comparator that scans it, one entry a cycle.
// Depends on wiq_pkg.
module wiq_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wiq_pkg::cls_ctl_t              ctl,
  input  logic [wiq_pkg::THR_AW-1:0]     thr_addr,
  input  logic [wiq_pkg::VALUE_W-1:0]    thr_wdata,
  input  logic signed [wiq_pkg::VALUE_W-1:0] elem,
  input  logic [wiq_pkg::NTHR_W-1:0]     n_thr,
  output wiq_pkg::cls_sts_t              sts
);
  import wiq_pkg::*;

  logic [VALUE_W-1:0]  thr_mem [THR_DEPTH];
  logic [VALUE_W-1:0]  thr_q_r;
  logic [THR_AW-1:0]   k_r, k_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [REGION_W-1:0] region_r, region_nxt;
  logic                hit, eq;

  assign hit = $signed(thr_q_r) >= elem;
  assign eq  = thr_q_r == elem;

  always_comb begin
    k_nxt      = k_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    region_nxt = region_r;
    if (ctl.start) begin
      k_nxt = '0;
      if (n_thr == '0) begin
        done_nxt   = 1'b1;
        region_nxt = '0;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (hit) begin
        done_nxt   = 1'b1;
        busy_nxt   = 1'b0;
        region_nxt = {k_r, eq};
      end else if (k_r == n_thr - NTHR_W'(1)) begin
        // above every threshold in use
        done_nxt   = 1'b1;
        busy_nxt   = 1'b0;
        region_nxt = {n_thr, 1'b0};
      end else begin
        k_nxt = k_r + THR_AW'(1);
      end
    end
  end

  // read ahead at the next index so each cycle compares one entry
  always_ff @(posedge clk) begin
    if (ctl.thr_we) begin
      thr_mem[thr_addr] <= thr_wdata;
    end
    thr_q_r <= thr_mem[k_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    region_r <= region_nxt;
  end

  assign sts.done   = done_r;
  assign sts.region = region_r;

endmodule

// File: rtl/core/wiq_stats.sv
// Gray byte table and region count table with per-entry valid bits.
// Depends on wiq_pkg.
module wiq_stats #(
  parameter int REGION_SLOTS = wiq_pkg::REGION_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wiq_pkg::stats_ctl_t             ctl,
  input  logic [$clog2(REGION_SLOTS)-1:0] rd_addr,
  input  logic [$clog2(REGION_SLOTS)-1:0] wr_addr,
  input  logic [wiq_pkg::GRAY_W-1:0]      gray_wdata,
  input  logic [wiq_pkg::COUNT_W-1:0]     cnt_wdata,
  output logic [wiq_pkg::GRAY_W-1:0]      gray_q,
  output logic [wiq_pkg::COUNT_W-1:0]     cnt_q
);
  import wiq_pkg::*;

  logic [GRAY_W-1:0]       gray_mem [REGION_SLOTS];
  logic [COUNT_W-1:0]      cnt_mem  [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] valid_r;
  logic [GRAY_W-1:0]       gray_q_r;
  logic [COUNT_W-1:0]      cnt_q_r;
  logic                    vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.gray_we) begin
      gray_mem[wr_addr] <= gray_wdata;
    end
    if (ctl.cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    gray_q_r <= gray_mem[rd_addr];
    cnt_q_r  <= cnt_mem[rd_addr];
  end

  // a count entry without its valid bit reads as zero; clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid_r <= '0;
      end else if (ctl.cnt_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      vld_q_r <= valid_r[rd_addr];
    end
  end

  assign gray_q = gray_q_r;
  assign cnt_q  = vld_q_r ? cnt_q_r : '0;

endmodule

// File: tb/sv/windowed_interval_quantizer_core_tb.sv
// Self-checking testbench for the windowed interval quantizer core: command words are
// sent through start/busy, each result word is predicted on acceptance and checked.
// Depends on wiq_pkg and the windowed_interval_quantizer_core RTL only.
`timescale 1ns / 100ps

module windowed_interval_quantizer_core_tb;
  import wiq_pkg::*;

  localparam int  REGION_SLOTS  = REGION_SLOTS_DEF;
  localparam int  DIM_LIMIT     = 1 << DIM_BITS_DEF;
  localparam int  RANDOM_WORDS  = 1300;
  localparam int  DRAIN_CYCLES  = 80;
  localparam longint RUN_LIMIT_NS = 40_000_000;

  typedef struct packed {
    logic [GRAY_W-1:0]   gray_out;
    logic [REGION_W-1:0] region;
    logic                in_window;
    logic                row_done;
    logic                matrix_done;
    logic [COUNT_W-1:0]  region_count;
    logic [STATUS_W-1:0] status;
  } quant_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           in_cmd;
  logic signed [VALUE_W-1:0]  in_value;
  logic [SLOT_W-1:0]          in_slot;
  logic [GRAY_W-1:0]          in_gray;
  logic                       out_valid;
  logic [GRAY_W-1:0]          out_gray_out;
  logic [REGION_W-1:0]        out_region;
  logic                       out_in_window;
  logic                       out_row_done;
  logic                       out_matrix_done;
  logic [COUNT_W-1:0]         out_region_count;
  logic [STATUS_W-1:0]        out_status;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // Quantizer state as predicted
  int                   set_cols, set_rows, set_col_lo, set_row_lo;
  int                   set_col_hi, set_row_hi, set_nthr;
  bit                   set_stats;
  logic [VALUE_W-1:0]   thr_tab [THR_DEPTH];
  logic [GRAY_W-1:0]    gray_tab [REGION_SLOTS];
  logic [COUNT_W-1:0]   hit_count [REGION_SLOTS];
  int                   col_pos, row_pos, elems_taken;

  quant_word_t expected_words[$];

  bit gaps_on;
  int fail_count, words_sent, words_checked, elems_in_window, settings_used;

  windowed_interval_quantizer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_slot          (in_slot),
    .in_gray          (in_gray),
    .out_valid        (out_valid),
    .out_gray_out     (out_gray_out),
    .out_region       (out_region),
    .out_in_window    (out_in_window),
    .out_row_done     (out_row_done),
    .out_matrix_done  (out_matrix_done),
    .out_region_count (out_region_count),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void reset_model();
    set_cols = 1; set_rows = 1;
    set_col_lo = 1; set_row_lo = 1;
    set_col_hi = 0; set_row_hi = 0;
    set_nthr = 1; set_stats = 1'b1;
    for (int k = 0; k < THR_DEPTH; k++) thr_tab[k] = '0;
    for (int k = 0; k < REGION_SLOTS; k++) begin
      gray_tab[k] = '0;
      hit_count[k] = '0;
    end
    col_pos = 0; row_pos = 0; elems_taken = 0;
  endfunction

  function automatic int clamp_dim(int d);
    if (d < 1) return 1;
    return (d > DIM_LIMIT) ? DIM_LIMIT : d;
  endfunction

  // First threshold not below the element wins, scanning upward
  function automatic int region_of(logic [VALUE_W-1:0] val);
    int n;
    n = set_nthr;
    if (n > (REGION_SLOTS - 1) / 2) n = (REGION_SLOTS - 1) / 2;
    if (n > THR_DEPTH) n = THR_DEPTH;
    for (int k = 0; k < n; k++)
      if ($signed(thr_tab[k]) >= $signed(val)) return (thr_tab[k] == val) ? 2 * k + 1 : 2 * k;
    return 2 * n;
  endfunction

  function automatic quant_word_t quantize_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                                                logic [SLOT_W-1:0] slot,
                                                logic [GRAY_W-1:0] gray);
    quant_word_t w;
    int cols, rows, total, cl, ch, rl, rh, c1, r1, rgn;
    bit inw;
    w = '0;
    if (cmd == CMD_ELEM) begin
      cols  = clamp_dim(set_cols);
      rows  = clamp_dim(set_rows);
      total = cols * rows;
      if (elems_taken >= total) begin
        w.status = ST_PAST_END;
      end else begin
        cl = set_col_lo; ch = set_col_hi;
        rl = set_row_lo; rh = set_row_hi;
        c1 = col_pos + 1;
        r1 = row_pos + 1;
        rgn = region_of(val);
        // an inverted window shows the whole matrix
        if (cl > ch || rl > rh) begin
          cl = 1; rl = 1; ch = cols; rh = rows;
        end
        inw = (c1 >= cl) && (c1 <= ch) && (r1 >= rl) && (r1 <= rh);
        if (rgn < REGION_SLOTS) begin
          w.gray_out = gray_tab[rgn];
          if (inw && hit_count[rgn] != COUNT_MAX) hit_count[rgn]++;
        end
        w.region    = rgn[REGION_W-1:0];
        w.in_window = inw;
        elems_taken++;
        // wrap on a column position at or past the column count, even a reduced one
        if (c1 >= cols) begin
          col_pos = 0;
          if (row_pos < int'(ROW_MAX)) row_pos++;
          if (row_pos >= rl && row_pos <= rh) w.row_done = 1'b1;
        end else begin
          col_pos = c1;
        end
        if (elems_taken == total) w.matrix_done = 1'b1;
      end
    end else if (cmd == CMD_THR) begin
      if (slot < THR_DEPTH) thr_tab[slot] = val;
      else w.status = ST_BAD_SLOT;
    end else if (cmd == CMD_COLOR) begin
      if (slot < REGION_SLOTS) gray_tab[slot] = gray;
      else w.status = ST_BAD_SLOT;
    end else if (cmd == CMD_READ) begin
      if (slot < REGION_SLOTS) w.region_count = set_stats ? hit_count[slot] : '0;
      else w.status = ST_BAD_SLOT;
    end else if (cmd == CMD_START) begin
      col_pos = 0; row_pos = 0; elems_taken = 0;
      for (int k = 0; k < REGION_SLOTS; k++) hit_count[k] = '0;
    end
    return w;
  endfunction

  // Hold start until the word is taken, then record its expected result
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                           logic [SLOT_W-1:0] slot, logic [GRAY_W-1:0] gray);
    quant_word_t w;
    if (gaps_on && $urandom_range(99) < 25) begin
      // let the block go idle first so the gap is seen as one
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_value <= val;
    in_slot  <= slot;
    in_gray  <= gray;
    do @(posedge clk); while (busy);
    w = quantize_word(cmd, val, slot, gray);
    expected_words.push_back(w);
    words_sent++;
    if (cmd == CMD_ELEM && w.in_window) elems_in_window++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0 || busy);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_COLS:     set_cols   = int'(data);
      CFG_ROWS:     set_rows   = int'(data);
      CFG_COL_LOW:  set_col_lo = int'(data);
      CFG_ROW_LOW:  set_row_lo = int'(data);
      CFG_COL_HIGH: set_col_hi = int'(data);
      CFG_ROW_HIGH: set_row_hi = int'(data);
      CFG_NTHR:     set_nthr   = int'(data[NTHR_W-1:0]);
      CFG_STATS:    set_stats  = data[0];
      default: ;
    endcase
  endtask

  task automatic write_settings(int cols, int rows, int cl, int rl, int ch, int rh,
                                int nthr_data, int stats_data);
    write_reg(CFG_COLS,     CFG_DATA_W'(cols));
    write_reg(CFG_ROWS,     CFG_DATA_W'(rows));
    write_reg(CFG_COL_LOW,  CFG_DATA_W'(cl));
    write_reg(CFG_ROW_LOW,  CFG_DATA_W'(rl));
    write_reg(CFG_COL_HIGH, CFG_DATA_W'(ch));
    write_reg(CFG_ROW_HIGH, CFG_DATA_W'(rh));
    write_reg(CFG_NTHR,     CFG_DATA_W'(nthr_data));
    write_reg(CFG_STATS,    CFG_DATA_W'(stats_data));
    settings_used++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    quant_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        check_field("gray_out",     32'(exp_w.gray_out),     32'(out_gray_out));
        check_field("region",       32'(exp_w.region),       32'(out_region));
        check_field("in_window",    32'(exp_w.in_window),    32'(out_in_window));
        check_field("row_done",     32'(exp_w.row_done),     32'(out_row_done));
        check_field("matrix_done",  32'(exp_w.matrix_done),  32'(out_matrix_done));
        check_field("region_count", 32'(exp_w.region_count), 32'(out_region_count));
        check_field("status",       32'(exp_w.status),       32'(out_status));
      end
    end
  end

  // Mostly near a loaded threshold so that equal and neighbouring regions are hit
  function automatic logic [VALUE_W-1:0] pick_element();
    int n;
    n = (set_nthr > (REGION_SLOTS - 1) / 2) ? (REGION_SLOTS - 1) / 2 : set_nthr;
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: begin
        if (n == 0) return $urandom;
        return thr_tab[$urandom_range(n - 1)] + 32'($urandom_range(2)) - 32'd1;
      end
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(19))
      0: return 0;
      1: return DIM_LIMIT;
      2: return 8191;
      3: return int'(CFG_DATA_W'($urandom));
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_edge(int dim);
    case ($urandom_range(9))
      0: return 0;
      1: return int'(CFG_DATA_W'($urandom));
      2: return 8191;
      default: return $urandom_range(0, ((dim > 9) ? 9 : dim) + 1);
    endcase
  endfunction

  task automatic pick_settings();
    int cols, rows, n;
    cols = pick_dim();
    rows = pick_dim();
    case ($urandom_range(9))
      0: n = 0;
      1: n = (REGION_SLOTS - 1) / 2;
      2: n = int'(NTHR_W'($urandom));
      default: n = $urandom_range(1, 8);
    endcase
    // upper data bits are don't-care for the narrow registers: drive them at random
    write_settings(cols, rows, pick_edge(cols), pick_edge(rows), pick_edge(cols),
                   pick_edge(rows), int'({7'($urandom), NTHR_W'(n)}),
                   int'({12'($urandom), 1'($urandom_range(99) < 80)}));
  endtask

  task automatic load_sorted_thresholds();
    logic [VALUE_W-1:0] level;
    int stride_bits, n;
    n = (set_nthr > (REGION_SLOTS - 1) / 2) ? (REGION_SLOTS - 1) / 2 : set_nthr;
    level = {1'b1, 31'($urandom)};
    stride_bits = $urandom_range(0, 24);
    for (int k = 0; k < n; k++) begin
      send_word(CMD_THR, level, SLOT_W'(k), GRAY_W'($urandom));
      level = level + 32'($urandom_range(0, 1 << stride_bits));
    end
  endtask

  // Write every threshold and gray entry so no element ever reads an unwritten one
  task automatic load_tables();
    for (int k = 0; k < THR_DEPTH; k++)
      send_word(CMD_THR, 32'((k - 32) * 65536), SLOT_W'(k), GRAY_W'($urandom));
    for (int k = 0; k < REGION_SLOTS; k++)
      send_word(CMD_COLOR, $urandom, SLOT_W'(k), GRAY_W'($urandom));
  endtask

  task automatic test_basic_commands();
    logic [CMD_W-1:0] spare;
    wait_idle();
    // 2x2 matrix, window on column 2 only
    write_settings(2, 2, 2, 1, 2, 2, 4, 1);
    send_word(CMD_THR, 32'h8000_0000, SLOT_W'(0), 8'h00);
    send_word(CMD_THR, $urandom, SLOT_W'(THR_DEPTH), 8'h00);
    send_word(CMD_THR, $urandom, 7'h7f, 8'h00);
    send_word(CMD_COLOR, '0, 7'h7f, 8'hff);
    send_word(CMD_ELEM, 32'h8000_0000, '0, '0);
    send_word(CMD_ELEM, 32'h7fff_ffff, '0, '0);
    send_word(CMD_ELEM, thr_tab[1], '0, '0);
    send_word(CMD_ELEM, thr_tab[1] - 32'd1, '0, '0);
    send_word(CMD_ELEM, $urandom, '0, '0);
    send_word(CMD_READ, '0, SLOT_W'(8), '0);
    send_word(CMD_READ, '0, SLOT_W'(3), '0);
    send_word(CMD_READ, '0, 7'h7f, '0);
    send_word(CMD_START, '0, '0, '0);
    send_word(CMD_READ, '0, SLOT_W'(3), '0);
    spare = CMD_W'($urandom_range(7, int'(CMD_START) + 1));
    send_word(spare, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
  endtask

  task automatic test_window_cases();
    wait_idle();
    // inverted window, no thresholds, statistics off
    write_settings(4, 2, 3, 2, 1, 1, 0, 0);
    send_word(CMD_START, '0, '0, '0);
    repeat (3) send_word(CMD_ELEM, $urandom, '0, '0);
    send_word(CMD_READ, '0, '0, '0);
    wait_idle();
    // shrink the columns under a position already past them
    write_reg(CFG_COLS, CFG_DATA_W'(2));
    write_reg(CFG_STATS, CFG_DATA_W'(1));
    send_word(CMD_ELEM, $urandom, '0, '0);
    send_word(CMD_ELEM, $urandom, '0, '0);
    send_word(CMD_READ, '0, '0, '0);
  endtask

  task automatic test_random_matrices();
    int base, phase, pick;
    logic [CMD_W-1:0] spare;
    base  = words_sent;
    phase = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      phase++;
      gaps_on = (phase % 6 != 2);
      wait_idle();
      pick_settings();
      send_word(CMD_START, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
      if ($urandom_range(3) == 0) load_sorted_thresholds();
      repeat ($urandom_range(40, 120)) begin
        pick = $urandom_range(99);
        if (pick < 72)
          send_word(CMD_ELEM, pick_element(), SLOT_W'($urandom), GRAY_W'($urandom));
        else if (pick < 82)
          send_word(CMD_READ, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
        else if (pick < 87)
          send_word(CMD_THR, pick_element(), SLOT_W'($urandom), GRAY_W'($urandom));
        else if (pick < 92)
          send_word(CMD_COLOR, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
        else if (pick < 95)
          send_word(CMD_START, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
        else begin
          spare = CMD_W'($urandom_range(7, int'(CMD_START) + 1));
          send_word(spare, $urandom, SLOT_W'($urandom), GRAY_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_cmd    <= CMD_ELEM;
    in_value  <= '0;
    in_slot   <= '0;
    in_gray   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COLS;
    cfg_data  <= '0;
    gaps_on = 1'b1;
    fail_count = 0; words_sent = 0; words_checked = 0;
    elems_in_window = 0; settings_used = 0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_tables();
    test_basic_commands();
    test_window_cases();
    test_random_matrices();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d elements counted in window) over %0d register settings;",
             words_sent, elems_in_window, settings_used);
    $display("%0d result words compared field by field.", words_checked);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
